>>> src/csot_pkg.sv
// ----------------------------------------------------------------------------
// csot_pkg: shared types and constants for the circle/shape overlap test
// Fixed widths of the datapath, derived from the axis fraction width, and the
// small helpers used by the pipeline.
// ----------------------------------------------------------------------------
package csot_pkg;

	localparam int AXIS_FRAC_BITS = 14;

	localparam int CRD_W = 32;   // signed coordinate
	localparam int RAD_W = 31;   // unsigned radius / half extent
	localparam int AXW   = 16;   // signed axis component

	localparam int DW   = CRD_W + 1;                  // center offset
	localparam int RSW  = RAD_W + 1;                  // radius sum
	localparam int PW   = DW + AXIS_FRAC_BITS + 1;    // axis projection
	localparam int EW   = RAD_W + AXIS_FRAC_BITS;     // scaled half extent
	localparam int CW   = EW + 1;                     // clamped projection
	localparam int MW   = EW + AXIS_FRAC_BITS + 1;    // axis * clamped projection
	localparam int XW   = DW + 2 * AXIS_FRAC_BITS + 1; // closest point offset
	localparam int HALF = (XW + 1) / 2;               // low half of a magnitude
	localparam int HIW  = XW - HALF;                  // high half of a magnitude
	localparam int QW   = 2 * XW;                     // square

	localparam logic signed [AXW-1:0] AXIS_ONE     = AXW'(2 ** AXIS_FRAC_BITS);
	localparam logic signed [AXW-1:0] AXIS_NEG_ONE = -AXIS_ONE;

	typedef logic signed [AXW-1:0] axis_t;

	// partial products of one square, split into high and low halves
	typedef struct packed {
		logic [2*HIW-1:0]    hh;
		logic [HIW+HALF-1:0] hl;
		logic [2*HALF-1:0]   ll;
	} sq_parts_t;

	function automatic axis_t sat_axis(axis_t v);
		axis_t r;
		if (v > AXIS_ONE) begin
			r = AXIS_ONE;
		end else if (v < AXIS_NEG_ONE) begin
			r = AXIS_NEG_ONE;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic sq_parts_t split_sq(logic [XW-1:0] m);
		logic [HIW-1:0]  hi;
		logic [HALF-1:0] lo;
		sq_parts_t       p;
		hi   = m[XW-1:HALF];
		lo   = m[HALF-1:0];
		p.hh = hi * hi;
		p.hl = hi * lo;
		p.ll = lo * lo;
		return p;
	endfunction

	function automatic logic [QW-1:0] join_sq(sq_parts_t p);
		return (QW'(p.hh) << (2 * HALF)) + (QW'(p.hl) << (HALF + 1)) + QW'(p.ll);
	endfunction

endpackage

>>> src/circle_shape_overlap_test.sv
// ----------------------------------------------------------------------------
// circle_shape_overlap_test: query circle versus circle or oriented box
// Nine-stage pipeline. Circle target: dx^2+dy^2 <= (r+ra)^2. Box target: the
// offset is projected on both axes, clamped to the half extents, the closest
// point is rebuilt and its squared distance compared with r^2, all exact.
// ----------------------------------------------------------------------------
//  channel  | valid / stall              | word
//  ---------+----------------------------+--------------------------------------
//  query    | query_valid / query_stall  | query_*, target_*, first/second_axis_*
//  result   | result_valid / result_stall| overlap
//
//  One word per cycle while the result is not stalled; one register stage per step
//  (offset, projection, clamp, axis products, closest point, magnitude,
//  half-width partial products, squares, sum and compare).
//  Reset clears only the stage valid bits.
//  Empty stages close up under a result stall; query_stall is raised only
//  when all nine stages hold words and the result is stalled.
// ----------------------------------------------------------------------------
module circle_shape_overlap_test (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               query_valid,
	output logic                               query_stall,
	input  logic signed [csot_pkg::CRD_W-1:0]  query_x,
	input  logic signed [csot_pkg::CRD_W-1:0]  query_y,
	input  logic        [csot_pkg::RAD_W-1:0]  query_radius,
	input  logic                               target_is_box,
	input  logic signed [csot_pkg::CRD_W-1:0]  target_x,
	input  logic signed [csot_pkg::CRD_W-1:0]  target_y,
	input  logic        [csot_pkg::RAD_W-1:0]  target_size_a,
	input  logic        [csot_pkg::RAD_W-1:0]  target_size_b,
	input  logic signed [csot_pkg::AXW-1:0]    first_axis_x,
	input  logic signed [csot_pkg::AXW-1:0]    first_axis_y,
	input  logic signed [csot_pkg::AXW-1:0]    second_axis_x,
	input  logic signed [csot_pkg::AXW-1:0]    second_axis_y,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic                               overlap
);
	import csot_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic valid_s6, valid_s7, valid_s8, valid_s9;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9;

	assign en_s9 = !valid_s9 || !result_stall;
	assign en_s8 = !valid_s8 || en_s9;
	assign en_s7 = !valid_s7 || en_s8;
	assign en_s6 = !valid_s6 || en_s7;
	assign en_s5 = !valid_s5 || en_s6;
	assign en_s4 = !valid_s4 || en_s5;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;

	assign query_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= query_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
			if (en_s6) valid_s6 <= valid_s5;
			if (en_s7) valid_s7 <= valid_s6;
			if (en_s8) valid_s8 <= valid_s7;
			if (en_s9) valid_s9 <= valid_s8;
		end
	end

	// ---- stage 1: center offset, radius sum, axis saturation
	logic signed [DW-1:0]    dx_s1, dy_s1;
	logic        [RSW-1:0]   rs_s1;
	logic        [RAD_W-1:0] qr_s1, sa_s1, sb_s1;
	logic                    box_s1;
	axis_t                   ax1_s1, ay1_s1, ax2_s1, ay2_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			dx_s1  <= DW'(query_x) - DW'(target_x);
			dy_s1  <= DW'(query_y) - DW'(target_y);
			rs_s1  <= RSW'(query_radius) + RSW'(target_size_a);
			qr_s1  <= query_radius;
			sa_s1  <= target_size_a;
			sb_s1  <= target_size_b;
			box_s1 <= target_is_box;
			ax1_s1 <= sat_axis(first_axis_x);
			ay1_s1 <= sat_axis(first_axis_y);
			ax2_s1 <= sat_axis(second_axis_x);
			ay2_s1 <= sat_axis(second_axis_y);
		end
	end

	// ---- stage 2: projections on both box axes
	logic signed [DW+AXW-1:0] pdx1, pdy1, pdx2, pdy2;
	logic signed [PW-1:0]     p1_s2, p2_s2;
	logic signed [DW-1:0]     dx_s2, dy_s2;
	logic        [RSW-1:0]    rs_s2;
	logic        [RAD_W-1:0]  qr_s2, sa_s2, sb_s2;
	logic                     box_s2;
	axis_t                    ax1_s2, ay1_s2, ax2_s2, ay2_s2;

	assign pdx1 = dx_s1 * ax1_s1;
	assign pdy1 = dy_s1 * ay1_s1;
	assign pdx2 = dx_s1 * ax2_s1;
	assign pdy2 = dy_s1 * ay2_s1;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			p1_s2  <= PW'(pdx1 + pdy1);
			p2_s2  <= PW'(pdx2 + pdy2);
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			rs_s2  <= rs_s1;
			qr_s2  <= qr_s1;
			sa_s2  <= sa_s1;
			sb_s2  <= sb_s1;
			box_s2 <= box_s1;
			ax1_s2 <= ax1_s1;
			ay1_s2 <= ay1_s1;
			ax2_s2 <= ax2_s1;
			ay2_s2 <= ay2_s1;
		end
	end

	// ---- stage 3: clamp projections to the scaled half extents
	logic signed [PW-1:0]    ea_w, eb_w;
	logic signed [PW-1:0]    c1_w, c2_w;
	logic signed [CW-1:0]    c1_s3, c2_s3;
	logic signed [DW-1:0]    dx_s3, dy_s3;
	logic        [RSW-1:0]   rs_s3;
	logic        [RAD_W-1:0] qr_s3;
	logic                    box_s3;
	axis_t                   ax1_s3, ay1_s3, ax2_s3, ay2_s3;

	assign ea_w = $signed(PW'({sa_s2, {AXIS_FRAC_BITS{1'b0}}}));
	assign eb_w = $signed(PW'({sb_s2, {AXIS_FRAC_BITS{1'b0}}}));

	always_comb begin
		if (p1_s2 > ea_w) begin
			c1_w = ea_w;
		end else if (p1_s2 < -ea_w) begin
			c1_w = -ea_w;
		end else begin
			c1_w = p1_s2;
		end
		if (p2_s2 > eb_w) begin
			c2_w = eb_w;
		end else if (p2_s2 < -eb_w) begin
			c2_w = -eb_w;
		end else begin
			c2_w = p2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			c1_s3  <= CW'(c1_w);
			c2_s3  <= CW'(c2_w);
			dx_s3  <= dx_s2;
			dy_s3  <= dy_s2;
			rs_s3  <= rs_s2;
			qr_s3  <= qr_s2;
			box_s3 <= box_s2;
			ax1_s3 <= ax1_s2;
			ay1_s3 <= ay1_s2;
			ax2_s3 <= ax2_s2;
			ay2_s3 <= ay2_s2;
		end
	end

	// ---- stage 4: axis times clamped projection
	logic signed [MW-1:0]    mx1_s4, mx2_s4, my1_s4, my2_s4;
	logic signed [DW-1:0]    dx_s4, dy_s4;
	logic        [RSW-1:0]   rs_s4;
	logic        [RAD_W-1:0] qr_s4;
	logic                    box_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			mx1_s4 <= ax1_s3 * c1_s3;
			mx2_s4 <= ax2_s3 * c2_s3;
			my1_s4 <= ay1_s3 * c1_s3;
			my2_s4 <= ay2_s3 * c2_s3;
			dx_s4  <= dx_s3;
			dy_s4  <= dy_s3;
			rs_s4  <= rs_s3;
			qr_s4  <= qr_s3;
			box_s4 <= box_s3;
		end
	end

	// ---- stage 5: closest point offset (box) or plain offset (circle)
	logic signed [XW-1:0] ex_w, ey_w;
	logic signed [XW-1:0] x_s5, y_s5;
	logic        [XW-1:0] r_s5;

	assign ex_w = (XW'(dx_s4) <<< (2 * AXIS_FRAC_BITS)) - XW'(mx1_s4) - XW'(mx2_s4);
	assign ey_w = (XW'(dy_s4) <<< (2 * AXIS_FRAC_BITS)) - XW'(my1_s4) - XW'(my2_s4);

	always_ff @(posedge clk) begin
		if (en_s5) begin
			x_s5 <= box_s4 ? ex_w : XW'(dx_s4);
			y_s5 <= box_s4 ? ey_w : XW'(dy_s4);
			r_s5 <= box_s4 ? (XW'(qr_s4) << (2 * AXIS_FRAC_BITS)) : XW'(rs_s4);
		end
	end

	// ---- stage 6: magnitudes
	logic [XW-1:0] mx_s6, my_s6, mr_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			mx_s6 <= x_s5[XW-1] ? unsigned'(-x_s5) : unsigned'(x_s5);
			my_s6 <= y_s5[XW-1] ? unsigned'(-y_s5) : unsigned'(y_s5);
			mr_s6 <= r_s5;
		end
	end

	// ---- stage 7: half-width partial products of the three squares
	sq_parts_t px_s7, py_s7, pr_s7;

	always_ff @(posedge clk) begin
		if (en_s7) begin
			px_s7 <= split_sq(mx_s6);
			py_s7 <= split_sq(my_s6);
			pr_s7 <= split_sq(mr_s6);
		end
	end

	// ---- stage 8: assemble squares
	logic [QW-1:0] qx_s8, qy_s8, qr2_s8;

	always_ff @(posedge clk) begin
		if (en_s8) begin
			qx_s8  <= join_sq(px_s7);
			qy_s8  <= join_sq(py_s7);
			qr2_s8 <= join_sq(pr_s7);
		end
	end

	// ---- stage 9: sum and compare; touching counts
	logic [QW:0] dist2_w;
	logic        ovl_s9;

	assign dist2_w = (QW+1)'(qx_s8) + (QW+1)'(qy_s8);

	always_ff @(posedge clk) begin
		if (en_s9) begin
			ovl_s9 <= dist2_w <= (QW+1)'(qr2_s8);
		end
	end

	assign result_valid = valid_s9;
	assign overlap      = ovl_s9;

endmodule

>>> src/csot_checker.sv
// ----------------------------------------------------------------------------
// csot_checker: port-level checks for circle_shape_overlap_test
// Watches the two channels and the back-pressure relation between them.
// ----------------------------------------------------------------------------
module csot_checker (
	input logic clk,
	input logic arst_n,
	input logic query_valid,
	input logic query_stall,
	input logic result_valid,
	input logic result_stall,
	input logic overlap
);

	// a stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(overlap))
		else $error("result word dropped or changed under stall");

	// the query side only backs up behind a stalled, occupied output
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		query_stall |-> result_valid && result_stall)
		else $error("query stalled without result back-pressure");

	// a full pipe stays full while the output stays stalled
	a_stall_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		query_stall |=> query_stall || !result_stall)
		else $error("query stall released while pipe still blocked");

endmodule

bind circle_shape_overlap_test csot_checker u_csot_checker (.*);

>>> tb/csot_overlap_checker.sv
// ----------------------------------------------------------------------------
// csot_overlap_checker: scoreboard for the circle/shape overlap test
// Watches the query and result channels. Every accepted query word gets its
// overlap bit predicted with exact 128-bit arithmetic and queued. Every
// accepted result word is compared against the oldest queued prediction.
// ----------------------------------------------------------------------------
module csot_overlap_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               query_valid,
	input  logic                               query_stall,
	input  logic signed [csot_pkg::CRD_W-1:0]  query_x,
	input  logic signed [csot_pkg::CRD_W-1:0]  query_y,
	input  logic        [csot_pkg::RAD_W-1:0]  query_radius,
	input  logic                               target_is_box,
	input  logic signed [csot_pkg::CRD_W-1:0]  target_x,
	input  logic signed [csot_pkg::CRD_W-1:0]  target_y,
	input  logic        [csot_pkg::RAD_W-1:0]  target_size_a,
	input  logic        [csot_pkg::RAD_W-1:0]  target_size_b,
	input  logic signed [csot_pkg::AXW-1:0]    first_axis_x,
	input  logic signed [csot_pkg::AXW-1:0]    first_axis_y,
	input  logic signed [csot_pkg::AXW-1:0]    second_axis_x,
	input  logic signed [csot_pkg::AXW-1:0]    second_axis_y,
	input  logic                               result_valid,
	input  logic                               result_stall,
	input  logic                               overlap,
	output int                                 mismatches,
	output int                                 pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import csot_pkg::*;

	typedef logic signed [127:0] wide_t;

	logic overlap_due[$];
	int   bad_cnt    = 0;
	int   due_cnt    = 0;
	int   result_idx = 0;

	assign mismatches = bad_cnt;
	assign pending    = due_cnt;

	function automatic wide_t clip(wide_t v, wide_t lim);
		if (v > lim) begin
			return lim;
		end
		if (v < -lim) begin
			return -lim;
		end
		return v;
	endfunction

	function automatic logic predict_overlap(
		input logic signed [CRD_W-1:0] qx,
		input logic signed [CRD_W-1:0] qy,
		input logic        [RAD_W-1:0] qr,
		input logic                    is_box,
		input logic signed [CRD_W-1:0] tx,
		input logic signed [CRD_W-1:0] ty,
		input logic        [RAD_W-1:0] sa,
		input logic        [RAD_W-1:0] sb,
		input axis_t                   a1x,
		input axis_t                   a1y,
		input axis_t                   a2x,
		input axis_t                   a2y
	);
		wide_t dx, dy, px, py, rq, ea, eb, unit;
		wide_t u1x, u1y, u2x, u2y, c1, c2, ex, ey;
		dx = qx;
		dy = qy;
		px = tx;
		py = ty;
		dx = dx - px;
		dy = dy - py;
		rq = qr;
		ea = sa;
		eb = sb;
		if (!is_box) begin
			return dx * dx + dy * dy <= (rq + ea) * (rq + ea);
		end
		unit = 128'sd1 <<< AXIS_FRAC_BITS;
		u1x  = clip(a1x, unit);
		u1y  = clip(a1y, unit);
		u2x  = clip(a2x, unit);
		u2y  = clip(a2y, unit);
		ea   = ea <<< AXIS_FRAC_BITS;
		eb   = eb <<< AXIS_FRAC_BITS;
		// projections onto each axis, clamped to the scaled half extents
		c1   = clip(dx * u1x + dy * u1y, ea);
		c2   = clip(dx * u2x + dy * u2y, eb);
		// query center minus closest box point, both at 2*AXIS_FRAC_BITS scale
		ex   = (dx <<< (2 * AXIS_FRAC_BITS)) - (u1x * c1 + u2x * c2);
		ey   = (dy <<< (2 * AXIS_FRAC_BITS)) - (u1y * c1 + u2y * c2);
		rq   = rq <<< (2 * AXIS_FRAC_BITS);
		return ex * ex + ey * ey <= rq * rq;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic due;
		if (!arst_n) begin
			overlap_due.delete();
			due_cnt = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (overlap_due.size() == 0) begin
					if (bad_cnt < 10) begin
						$display("result word %0d arrived with nothing expected (overlap %0b)",
							result_idx, overlap);
					end
					bad_cnt++;
				end else begin
					due = overlap_due.pop_front();
					if (overlap !== due) begin
						if (bad_cnt < 10) begin
							$display("result word %0d: overlap expected %0b, got %0b",
								result_idx, due, overlap);
						end
						bad_cnt++;
					end
				end
				result_idx++;
			end
			if (query_valid && !query_stall) begin
				overlap_due = {overlap_due, predict_overlap(query_x, query_y, query_radius,
					target_is_box, target_x, target_y, target_size_a, target_size_b,
					first_axis_x, first_axis_y, second_axis_x, second_axis_y)};
			end
			due_cnt = overlap_due.size();
		end
	end

endmodule

>>> tb/tb_circle_shape_overlap_test.sv
// ----------------------------------------------------------------------------
// tb_circle_shape_overlap_test: stimulus and verdict for the overlap test
// Drives a directed set of circle and box targets (touching, just apart,
// extreme coordinates, saturated and degenerate axes, zero sizes), then
// about 1400 random words clustered so hits and misses both occur. Both
// channels idle at random; the checker beside the block does the compare.
// ----------------------------------------------------------------------------
module tb_circle_shape_overlap_test;
	timeunit 1ns;
	timeprecision 1ps;
	import csot_pkg::*;

	localparam int          RANDOM_WORDS = 1400;
	localparam int unsigned QUIET_LIMIT  = 4000;
	localparam logic [31:0] U1           = 32'h0001_0000;   // 1.0 in Q16.16
	localparam logic [31:0] CRD_MIN      = 32'h8000_0000;
	localparam logic [31:0] CRD_MAX      = 32'h7FFF_FFFF;
	localparam logic [31:0] RAD_MAX      = 32'h7FFF_FFFF;
	localparam logic [15:0] AX1          = 16'sd16384;
	localparam logic [15:0] AXM1         = -16'sd16384;
	localparam logic [15:0] AX45         = 16'sd11585;

	typedef struct packed {
		logic [CRD_W-1:0] qx;
		logic [CRD_W-1:0] qy;
		logic [RAD_W-1:0] qr;
		logic             is_box;
		logic [CRD_W-1:0] tx;
		logic [CRD_W-1:0] ty;
		logic [RAD_W-1:0] sa;
		logic [RAD_W-1:0] sb;
		logic [AXW-1:0]   a1x;
		logic [AXW-1:0]   a1y;
		logic [AXW-1:0]   a2x;
		logic [AXW-1:0]   a2y;
	} shape_word_t;

	logic                     clk           = 1'b0;
	logic                     arst_n        = 1'b0;
	logic                     query_valid   = 1'b0;
	logic                     query_stall;
	logic signed [CRD_W-1:0]  query_x       = '0;
	logic signed [CRD_W-1:0]  query_y       = '0;
	logic        [RAD_W-1:0]  query_radius  = '0;
	logic                     target_is_box = 1'b0;
	logic signed [CRD_W-1:0]  target_x      = '0;
	logic signed [CRD_W-1:0]  target_y      = '0;
	logic        [RAD_W-1:0]  target_size_a = '0;
	logic        [RAD_W-1:0]  target_size_b = '0;
	logic signed [AXW-1:0]    first_axis_x  = '0;
	logic signed [AXW-1:0]    first_axis_y  = '0;
	logic signed [AXW-1:0]    second_axis_x = '0;
	logic signed [AXW-1:0]    second_axis_y = '0;
	logic                     result_valid;
	logic                     result_stall  = 1'b0;
	logic                     overlap;
	int                       mismatches;
	int                       pending;
	logic                     calm          = 1'b0;
	int unsigned              quiet_cycles  = 0;

	circle_shape_overlap_test dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.query_valid   (query_valid),
		.query_stall   (query_stall),
		.query_x       (query_x),
		.query_y       (query_y),
		.query_radius  (query_radius),
		.target_is_box (target_is_box),
		.target_x      (target_x),
		.target_y      (target_y),
		.target_size_a (target_size_a),
		.target_size_b (target_size_b),
		.first_axis_x  (first_axis_x),
		.first_axis_y  (first_axis_y),
		.second_axis_x (second_axis_x),
		.second_axis_y (second_axis_y),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.overlap       (overlap)
	);

	csot_overlap_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.query_valid   (query_valid),
		.query_stall   (query_stall),
		.query_x       (query_x),
		.query_y       (query_y),
		.query_radius  (query_radius),
		.target_is_box (target_is_box),
		.target_x      (target_x),
		.target_y      (target_y),
		.target_size_a (target_size_a),
		.target_size_b (target_size_b),
		.first_axis_x  (first_axis_x),
		.first_axis_y  (first_axis_y),
		.second_axis_x (second_axis_x),
		.second_axis_y (second_axis_y),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.overlap       (overlap),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(negedge clk) begin
		result_stall <= !calm && ($urandom_range(0, 99) < 27);
	end

	// no word moved on either channel for too long: hung
	always @(posedge clk) begin
		if (arst_n) begin
			if ((query_valid && !query_stall) || (result_valid && !result_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("tb_circle_shape_overlap_test: done, errors");
				$finish;
			end
		end
	end

	function automatic shape_word_t make_word(
		input logic             is_box,
		input logic [CRD_W-1:0] qx,
		input logic [CRD_W-1:0] qy,
		input logic [CRD_W-1:0] qr,
		input logic [CRD_W-1:0] tx,
		input logic [CRD_W-1:0] ty,
		input logic [CRD_W-1:0] sa,
		input logic [CRD_W-1:0] sb,
		input logic [AXW-1:0]   a1x,
		input logic [AXW-1:0]   a1y,
		input logic [AXW-1:0]   a2x,
		input logic [AXW-1:0]   a2y
	);
		shape_word_t w;
		w = '{qx: qx, qy: qy, qr: qr[RAD_W-1:0], is_box: is_box, tx: tx, ty: ty,
			sa: sa[RAD_W-1:0], sb: sb[RAD_W-1:0],
			a1x: a1x, a1y: a1y, a2x: a2x, a2y: a2y};
		return w;
	endfunction

	// target placed near the query at a random scale, so hits and misses mix
	function automatic shape_word_t random_word();
		shape_word_t    w;
		logic [287:0]   raw;
		int unsigned    sc;
		longint         span;
		longint         ox;
		longint         oy;
		int unsigned    pick;
		real            ang;
		raw      = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom(), $urandom()};
		w        = raw[$bits(shape_word_t)-1:0];
		w.is_box = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 9) != 0) begin
			sc   = $urandom_range(0, 29);
			span = longint'(1) << sc;
			w.qr = RAD_W'($urandom_range(0, 32'(span)));
			w.sa = RAD_W'($urandom_range(0, 32'(span)));
			w.sb = RAD_W'($urandom_range(0, 32'(span)));
			ox   = longint'($urandom_range(0, 32'(4 * span))) - 2 * span;
			oy   = longint'($urandom_range(0, 32'(4 * span))) - 2 * span;
			w.tx = w.qx + 32'(ox);
			w.ty = w.qy + 32'(oy);
		end
		pick = $urandom_range(0, 99);
		if (pick < 65) begin
			ang   = real'($urandom_range(0, 35999)) * 3.14159265358979 / 18000.0;
			w.a1x = 16'($rtoi($cos(ang) * 16384.0));
			w.a1y = 16'($rtoi($sin(ang) * 16384.0));
			if ($urandom_range(0, 1)) begin
				w.a2x = -w.a1y;
				w.a2y = w.a1x;
			end else begin
				w.a2x = w.a1y;
				w.a2y = -w.a1x;
			end
		end else if (pick < 85) begin
			w.a1x = 16'($urandom_range(0, 32768)) - AX1;
			w.a1y = 16'($urandom_range(0, 32768)) - AX1;
			w.a2x = 16'($urandom_range(0, 32768)) - AX1;
			w.a2y = 16'($urandom_range(0, 32768)) - AX1;
		end
		return w;
	endfunction

	task automatic send_word(input shape_word_t w);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 27) begin
			query_valid <= 1'b0;
			@(negedge clk);
		end
		query_x       <= w.qx;
		query_y       <= w.qy;
		query_radius  <= w.qr;
		target_is_box <= w.is_box;
		target_x      <= w.tx;
		target_y      <= w.ty;
		target_size_a <= w.sa;
		target_size_b <= w.sb;
		first_axis_x  <= w.a1x;
		first_axis_y  <= w.a1y;
		second_axis_x <= w.a2x;
		second_axis_y <= w.a2y;
		query_valid   <= 1'b1;
		@(posedge clk);
		while (query_stall) begin
			@(posedge clk);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		query_valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// circle targets: exact touch, one lsb apart, zero radii, extremes
		send_word(make_word(1'b0, 0, 0, 3 * U1, 5 * U1, 0, 2 * U1, 0, 0, 0, 0, 0));
		send_word(make_word(1'b0, 0, 0, 3 * U1, 5 * U1 + 1, 0, 2 * U1, 0, 0, 0, 0, 0));
		send_word(make_word(1'b0, 7, -7, 0, 7, -7, 0, 0, 0, 0, 0, 0));
		send_word(make_word(1'b0, CRD_MIN, CRD_MIN, RAD_MAX, CRD_MAX, CRD_MAX, RAD_MAX,
			RAD_MAX, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF));
		send_word(make_word(1'b0, CRD_MAX, CRD_MIN, RAD_MAX, CRD_MAX, CRD_MIN, RAD_MAX,
			0, 0, 0, 0, 0));
		send_word(make_word(1'b0, CRD_MIN, 0, RAD_MAX, CRD_MAX, 0, 0, 0, 0, 0, 0, 0));
		// axis-aligned box: inside, edge touch, just short, corner touch and miss
		send_word(make_word(1'b1, 0, 0, 0, 0, 0, 2 * U1, U1, AX1, 0, 0, AX1));
		send_word(make_word(1'b1, 3 * U1, 0, U1, 0, 0, 2 * U1, U1, AX1, 0, 0, AX1));
		send_word(make_word(1'b1, 3 * U1, 0, U1 - 1, 0, 0, 2 * U1, U1, AX1, 0, 0, AX1));
		send_word(make_word(1'b1, 5 * U1, 5 * U1, 5 * U1, 0, 0, 2 * U1, U1, AX1, 0, 0, AX1));
		send_word(make_word(1'b1, 5 * U1, 5 * U1, 5 * U1 - 1, 0, 0, 2 * U1, U1,
			AX1, 0, 0, AX1));
		// rotated box, out-of-range axes that saturate, point box, zero axes
		send_word(make_word(1'b1, U1, -U1, 0, 0, 0, U1, U1, AX45, AX45, -AX45, AX45));
		send_word(make_word(1'b1, 3 * U1, U1, U1, 0, 0, 2 * U1, U1,
			16'h7FFF, 16'h8000, 16'h4001, 16'hBFFF));
		send_word(make_word(1'b1, 9, 9, 0, 9, 9, 0, 0, AX1, 0, 0, AX1));
		send_word(make_word(1'b1, 10, 9, 0, 9, 9, 0, 0, AX1, 0, 0, AX1));
		send_word(make_word(1'b1, 3 * U1, 4 * U1, 5 * U1, 0, 0, RAD_MAX, RAD_MAX, 0, 0, 0, 0));
		// non-orthogonal axes, both the same direction
		send_word(make_word(1'b1, 0, 3 * U1, 2 * U1, 0, 0, U1, U1, AX1, 0, AX1, 0));
		// extreme coordinates and sizes with negative and non-unit axes
		send_word(make_word(1'b1, CRD_MIN, CRD_MIN, RAD_MAX, CRD_MAX, CRD_MAX, RAD_MAX,
			RAD_MAX, AXM1, 0, 0, AXM1));
		send_word(make_word(1'b1, CRD_MAX, CRD_MIN, RAD_MAX, CRD_MIN, CRD_MAX, RAD_MAX,
			RAD_MAX, AX1, AX1, AXM1, AX1));
		send_word(make_word(1'b1, CRD_MIN, CRD_MAX, 0, CRD_MAX, CRD_MIN, 0, 0,
			16'h8000, 16'h7FFF, 16'h8000, 16'h8000));
		send_word(make_word(1'b1, CRD_MAX, CRD_MAX, 0, CRD_MIN, CRD_MIN, RAD_MAX, 0,
			AX45, AXM1, 0, AX1));
		drain_results();

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == 500) begin
				calm <= 1'b1;
			end else if (i == 800) begin
				calm <= 1'b0;
			end else if (i % 400 == 399) begin
				drain_results();
			end
			send_word(random_word());
		end

		drain_results();
		repeat (12) @(negedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("tb_circle_shape_overlap_test: done, clean");
		end else begin
			$display("tb_circle_shape_overlap_test: done, errors");
		end
		$finish;
	end

endmodule

>>> filelist.f
src/csot_pkg.sv
src/circle_shape_overlap_test.sv
src/csot_checker.sv
tb/csot_overlap_checker.sv
tb/tb_circle_shape_overlap_test.sv
